[design/pdd_pkg.sv]
// Shared constants and types of the PID differential drive core.
`default_nettype none

package pdd_pkg;

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CfgTarget   = 3'd0;
  localparam cfg_idx_t CfgPropGain = 3'd1;
  localparam cfg_idx_t CfgIntGain  = 3'd2;
  localparam cfg_idx_t CfgDerGain  = 3'd3;
  localparam cfg_idx_t CfgIntLimit = 3'd4;
  localparam cfg_idx_t CfgDrvLimit = 3'd5;
  localparam cfg_idx_t CfgRunLimit = 3'd6;

  // Register reset values.
  localparam logic signed [12:0] TargetReset   = 13'sd0;
  localparam logic [15:0]        PropGainReset = 16'd1850;
  localparam logic [15:0]        IntGainReset  = 16'd2;
  localparam logic [15:0]        DerGainReset  = 16'd2;
  localparam logic [14:0]        IntLimitReset = 15'd2850;
  localparam logic [15:0]        DrvLimitReset = 16'd8500;
  localparam logic [31:0]        RunLimitReset = 32'd180000;

  // Reciprocal multipliers for truncating division by constants.
  // floor(x / d) == (x * Mul) >> Shift over the full magnitude range of x.
  localparam logic [15:0] Div9Mul     = 16'd58255;
  localparam int unsigned Div9Shift   = 19;
  localparam logic [29:0] Div100Mul   = 30'd687194768;
  localparam int unsigned Div100Shift = 36;
  // Integral increment: gain * err * 2 / 1000 equals gain * err / 500.
  localparam logic [28:0] Div500Mul   = 29'd274877907;
  localparam int unsigned Div500Shift = 37;
  // Derivative divisor: 1000 * 6 * sample interval of 2 ms.
  localparam logic [31:0] Div12kMul   = 32'd2932031008;
  localparam int unsigned Div12kShift = 45;
  // Wheel scaling: 100 * x / 12500 equals x / 125.
  localparam logic [17:0] Div125Mul   = 18'd134218;
  localparam int unsigned Div125Shift = 24;

  localparam logic [14:0] SpeedFast = 15'd12500;
  localparam logic [14:0] SpeedSlow = 15'd9500;
  localparam logic signed [16:0] Deadband = 17'sd1500;

  localparam logic [6:0] LeftMin  = 7'd1;
  localparam logic [6:0] RightMin = 7'd8;
  localparam logic [6:0] DriveMax = 7'd100;

  typedef logic signed [13:0] err_t;
  typedef logic signed [16:0] integ_t;

endpackage

`default_nettype wire

[design/pid_differential_drive_core.sv]
// PID line-follower drive core: seven-stage pipeline from samples to wheel percentages.
//
//  Channel  Direction  Handshake                 Payload
//  in       sink       in_valid_i / in_ready_o   sample_0_i..sample_3_i, elapsed_ms_i
//  out      source     out_valid_o / out_ready_i left_drive_o, right_drive_o, running_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item enters per cycle while in_ready_o is high; each result passes stages 0 to 6 in turn.
// Along the way sit the reciprocal multipliers (divide by 9, by 100/500/12000,
// by 125), each followed by a register. Error history and the integral are updated in
// their own stages, in item order. Reset clears the valid bits, the state and the
// registers to their defaults. A stalled output stops only the stages behind a full
// stage, so empty stages keep filling.
`default_nettype none

module pid_differential_drive_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  [11:0]            sample_0_i,
  input  wire  [11:0]            sample_1_i,
  input  wire  [11:0]            sample_2_i,
  input  wire  [11:0]            sample_3_i,
  input  wire  [31:0]            elapsed_ms_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic [6:0]             left_drive_o,
  output logic [6:0]             right_drive_o,
  output logic                   running_o,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire  pdd_pkg::cfg_idx_t cfg_index_i,
  input  wire  [31:0]            cfg_data_i
);
  import pdd_pkg::*;

  localparam int unsigned NumStages = 7;

  // Configuration registers.
  logic signed [12:0] target_q;
  logic [15:0]        prop_gain_q;
  logic [15:0]        integ_gain_q;
  logic [15:0]        deriv_gain_q;
  logic [14:0]        integ_limit_q;
  logic [15:0]        drive_limit_q;
  logic [31:0]        run_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q      <= TargetReset;
      prop_gain_q   <= PropGainReset;
      integ_gain_q  <= IntGainReset;
      deriv_gain_q  <= DerGainReset;
      integ_limit_q <= IntLimitReset;
      drive_limit_q <= DrvLimitReset;
      run_limit_q   <= RunLimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTarget:   target_q      <= $signed(cfg_data_i[12:0]);
        CfgPropGain: prop_gain_q   <= cfg_data_i[15:0];
        CfgIntGain:  integ_gain_q  <= cfg_data_i[15:0];
        CfgDerGain:  deriv_gain_q  <= cfg_data_i[15:0];
        CfgIntLimit: integ_limit_q <= cfg_data_i[14:0];
        CfgDrvLimit: drive_limit_q <= cfg_data_i[15:0];
        CfgRunLimit: run_limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor loads.
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;
  logic [NumStages-1:0] run_q;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      run_q[0] <= elapsed_ms_i < run_limit_q;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (en[i]) begin
        run_q[i] <= run_q[i-1];
      end
    end
  end

  // Stage 0: weighted sums of the two sample pairs.
  logic [15:0] pos_sum_q, neg_sum_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pos_sum_q <= 16'(sample_3_i) * 16'd7 + 16'(sample_2_i) * 16'd2;
      neg_sum_q <= 16'(sample_1_i) * 16'd2 + 16'(sample_0_i) * 16'd7;
    end
  end

  // Stage 1: divide both sums by nine, form the position error.
  logic [31:0] pos_prod, neg_prod;
  logic [12:0] pos_quo, neg_quo;
  logic signed [13:0] est;
  err_t err_q;

  assign pos_prod = 32'(pos_sum_q) * 32'(Div9Mul);
  assign neg_prod = 32'(neg_sum_q) * 32'(Div9Mul);
  assign pos_quo  = 13'(pos_prod >> Div9Shift);
  assign neg_quo  = 13'(neg_prod >> Div9Shift);
  assign est      = $signed({1'b0, pos_quo}) - $signed({1'b0, neg_quo});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      err_q <= 14'(target_q) - est;
    end
  end

  // Stage 2: gain products and the four-tap difference; error history shifts here.
  err_t err_h1_q, err_h2_q, err_h3_q;
  logic signed [17:0] dsum;
  logic signed [30:0] pprod_q, iprod_q;
  logic signed [34:0] dprod_q;
  logic hist_upd;

  assign dsum = 18'(err_q) + 18'sd3 * 18'(err_h1_q) - 18'sd3 * 18'(err_h2_q) - 18'(err_h3_q);
  assign hist_upd = en[2] && valid_q[1] && run_q[1];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pprod_q <= 31'($signed({1'b0, prop_gain_q})) * 31'(err_q);
      iprod_q <= 31'($signed({1'b0, integ_gain_q})) * 31'(err_q);
      dprod_q <= 35'($signed({1'b0, deriv_gain_q})) * 35'(dsum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_h1_q <= '0;
      err_h2_q <= '0;
      err_h3_q <= '0;
    end else if (hist_upd) begin
      err_h1_q <= err_q;
      err_h2_q <= err_h1_q;
      err_h3_q <= err_h2_q;
    end
  end

  // Stage 3: truncating divisions on magnitudes, sign restored afterward.
  logic [28:0] pmag, imag;
  logic [31:0] dmag;
  logic [58:0] pquo_full;
  logic [57:0] iquo_full;
  logic [63:0] dquo_full;
  logic [22:0] pquo;
  logic [20:0] iquo;
  logic [18:0] dquo;
  logic signed [23:0] up_q;
  logic signed [21:0] iinc_q;
  logic signed [19:0] ud_q;

  assign pmag = 29'(pprod_q[30] ? -pprod_q : pprod_q);
  assign imag = 29'(iprod_q[30] ? -iprod_q : iprod_q);
  assign dmag = 32'(dprod_q[34] ? -dprod_q : dprod_q);
  assign pquo_full = 59'(pmag) * 59'(Div100Mul);
  assign iquo_full = 58'(imag) * 58'(Div500Mul);
  assign dquo_full = 64'(dmag) * 64'(Div12kMul);
  assign pquo = 23'(pquo_full >> Div100Shift);
  assign iquo = 21'(iquo_full >> Div500Shift);
  assign dquo = 19'(dquo_full >> Div12kShift);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      up_q   <= pprod_q[30] ? -$signed({1'b0, pquo}) : $signed({1'b0, pquo});
      iinc_q <= iprod_q[30] ? -$signed({1'b0, iquo}) : $signed({1'b0, iquo});
      ud_q   <= dprod_q[34] ? -$signed({1'b0, dquo}) : $signed({1'b0, dquo});
    end
  end

  // Stage 4: integral accumulate and clamp.
  integ_t integ_acc_q, integ_new, integ_q;
  logic signed [22:0] isum, ilim;
  logic signed [23:0] up4_q;
  logic signed [19:0] ud4_q;
  logic integ_upd;

  assign isum = 23'(integ_acc_q) + 23'(iinc_q);
  assign ilim = $signed({8'b0, integ_limit_q});
  assign integ_upd = en[4] && valid_q[3] && run_q[3];

  always_comb begin
    if (isum > ilim) begin
      integ_new = 17'(ilim);
    end else if (isum < -ilim) begin
      integ_new = 17'(-ilim);
    end else begin
      integ_new = 17'(isum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      integ_q <= integ_new;
      up4_q   <= up_q;
      ud4_q   <= ud_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_acc_q <= '0;
    end else if (integ_upd) begin
      integ_acc_q <= integ_new;
    end
  end

  // Stage 5: total drive, clamped to the drive limit.
  logic signed [24:0] usum, dlim;
  logic signed [16:0] u_q;

  assign usum = 25'(up4_q) + 25'(integ_q) + 25'(ud4_q);
  assign dlim = $signed({9'b0, drive_limit_q});

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      if (usum > dlim) begin
        u_q <= 17'(dlim);
      end else if (usum < -dlim) begin
        u_q <= 17'(-dlim);
      end else begin
        u_q <= 17'(usum);
      end
    end
  end

  // Stage 6: speed by deadband, wheel split and clamp; zero drive once the run limit is reached.
  logic [14:0] speed;
  logic signed [17:0] lnum, rnum;
  logic [16:0] lmag, rmag;
  logic [34:0] lquo_full, rquo_full;
  logic [9:0] lquo, rquo;
  logic [6:0] left_d, right_d;
  logic [6:0] left_q, right_q;

  assign speed = (u_q < Deadband && u_q > -Deadband) ? SpeedFast : SpeedSlow;
  assign lnum  = $signed({3'b0, speed}) - 18'(u_q);
  assign rnum  = $signed({3'b0, speed}) + 18'(u_q);
  assign lmag  = 17'(lnum[17] ? -lnum : lnum);
  assign rmag  = 17'(rnum[17] ? -rnum : rnum);
  assign lquo_full = 35'(lmag) * 35'(Div125Mul);
  assign rquo_full = 35'(rmag) * 35'(Div125Mul);
  assign lquo = 10'(lquo_full >> Div125Shift);
  assign rquo = 10'(rquo_full >> Div125Shift);

  // A negative quotient always lands on the lower clamp.
  always_comb begin
    if (lnum[17] || lquo < 10'(LeftMin)) begin
      left_d = LeftMin;
    end else if (lquo > 10'(DriveMax)) begin
      left_d = DriveMax;
    end else begin
      left_d = lquo[6:0];
    end
    if (rnum[17] || rquo < 10'(RightMin)) begin
      right_d = RightMin;
    end else if (rquo > 10'(DriveMax)) begin
      right_d = DriveMax;
    end else begin
      right_d = rquo[6:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      left_q  <= run_q[5] ? left_d : 7'd0;
      right_q <= run_q[5] ? right_d : 7'd0;
    end
  end

  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign running_o     = run_q[NumStages-1];

  // The integral never leaves its clamp right after an update.
  a_integ_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_upd |=> (integ_acc_q <= $signed({2'b0, $past(integ_limit_q)}))
               && (integ_acc_q >= -$signed({2'b0, $past(integ_limit_q)})))
    else $error("integral accumulator outside its limit");

  a_hist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[2] && valid_q[1] && !run_q[1]) |=> $stable(err_h1_q) && $stable(err_h3_q))
    else $error("error history changed for a stopped item");

  a_drive_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[5] |-> (u_q <= 17'(dlim)) && (u_q >= 17'(-dlim)))
    else $error("drive outside its limit");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && running_o) |-> (left_drive_o >= LeftMin) && (left_drive_o <= DriveMax)
                                && (right_drive_o >= RightMin) && (right_drive_o <= DriveMax))
    else $error("wheel percentage out of range while running");

  a_out_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !running_o) |-> (left_drive_o == 7'd0) && (right_drive_o == 7'd0))
    else $error("nonzero drive after the run limit");

endmodule

`default_nettype wire
